>>> rtl/core/olad_pkg.sv
// olad_pkg: shared types and codes for the ordered list block
// holds operation and status codes, controller states and the cell control struct
// no dependencies
package olad_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_DELETE = 2'd1,
		OP_DUMP   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_APPENDED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_ELEMENT   = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_DEL  = 2'd1,
		S_DUMP = 2'd2
	} state_t;

	// controls broadcast to every cell of the chain
	typedef struct packed {
		logic app;  // write value into the tail slot
		logic cap;  // register per-cell compare result
		logic del;  // close the gap behind the first match
		logic rot;  // rotate list one place toward the head
	} cell_ctl_t;

endpackage

>>> rtl/core/olad_cell.sv
// olad_cell: one slot of the list chain
// holds one entry and its registered match flag, hands data to the neighbor toward the head
// depends on olad_pkg
module olad_cell
	import olad_pkg::*;
(
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic                     live,
	input  logic                     is_tail,
	input  logic                     is_last,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [DATA_W-1:0] next_data,
	input  logic signed [DATA_W-1:0] head_data,
	input  logic                     hit_in,
	output logic signed [DATA_W-1:0] data,
	output logic                     hit_out
);

	logic signed [DATA_W-1:0] data_q;
	logic                     match_q;

	// first match at or before this slot means this slot takes its neighbor
	assign hit_out = hit_in | match_q;
	assign data    = data_q;

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			match_q <= live && (data_q == value);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.app && is_tail) begin
			data_q <= value;
		end else if (ctl.del && hit_out) begin
			data_q <= next_data;
		end else if (ctl.rot) begin
			data_q <= is_last ? head_data : next_data;
		end
	end

endmodule

>>> rtl/core/ordered_list_append_delete_dump.sv
// Ordered list of up to DEPTH signed 32-bit values kept as a chain of cells, head in cell 0.
// Append answers appended, or full when DEPTH entries are held. On a delete every cell first
// registers the compare of its entry with the value, then the first match from the head is
// closed up by the matching cell and each later cell taking its neighbor's entry; answer
// deleted or not found. Dump rotates the held entries one place per cycle and emits the head
// each cycle, last set on the final beat; an empty list answers list empty. A stalled dump
// beat pauses the rotation. One item is worked on at a time; a waiting result stalls the input
// unless that result is taken in the same cycle. Operation code 3 is taken and gives no result.
module ordered_list_append_delete_dump
	import olad_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               operation,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               status,
	output logic signed [DATA_W-1:0] element,
	output logic                     last
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	state_t                   state_q, state_d;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            dcnt_q;
	logic                     out_valid_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] element_q;
	logic                     last_q;

	cell_ctl_t                ctl;
	logic                     out_free;
	logic                     ld_out;
	status_t                  st_d;
	logic signed [DATA_W-1:0] elem_d;
	logic                     last_d;
	logic                     cnt_inc, cnt_dec, dcnt_clr, dcnt_inc;
	logic                     full, found, dump_end;

	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic                     hit [DEPTH+1];

	assign hit[0] = 1'b0;
	assign found  = hit[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] nxt;
		if (i == DEPTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end

		olad_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.live      (CW'(i) < count_q),
			.is_tail   (CW'(i) == count_q),
			.is_last   (CW'(i + 1) == count_q),
			.value     (value),
			.next_data (nxt),
			.head_data (cell_data[0]),
			.hit_in    (hit[i]),
			.data      (cell_data[i]),
			.hit_out   (hit[i+1])
		);
	end

	assign out_free = !out_valid_q || !out_stall;
	assign full     = (count_q == CW'(DEPTH));
	assign dump_end = ((dcnt_q + CW'(1)) == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		ctl      = '0;
		ld_out   = 1'b0;
		st_d     = ST_APPENDED;
		elem_d   = '0;
		last_d   = 1'b1;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		dcnt_clr = 1'b0;
		dcnt_inc = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = !out_free;
				if (in_valid && out_free) begin
					case (operation)
						OP_APPEND: begin
							ld_out = 1'b1;
							if (full) begin
								st_d = ST_FULL;
							end else begin
								ctl.app = 1'b1;
								cnt_inc = 1'b1;
								st_d    = ST_APPENDED;
							end
						end
						OP_DELETE: begin
							ctl.cap = 1'b1;
							state_d = S_DEL;
						end
						OP_DUMP: begin
							if (count_q == '0) begin
								ld_out = 1'b1;
								st_d   = ST_EMPTY;
							end else begin
								dcnt_clr = 1'b1;
								state_d  = S_DUMP;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_DEL: begin
				// result slot was freed when the delete beat was taken
				ld_out  = 1'b1;
				ctl.del = 1'b1;
				cnt_dec = found;
				st_d    = found ? ST_DELETED : ST_NOT_FOUND;
				state_d = S_IDLE;
			end
			S_DUMP: begin
				if (out_free) begin
					ld_out   = 1'b1;
					st_d     = ST_ELEMENT;
					elem_d   = cell_data[0];
					last_d   = dump_end;
					ctl.rot  = 1'b1;
					dcnt_inc = 1'b1;
					if (dump_end) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dcnt_q  <= '0;
		end else begin
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (dcnt_clr) begin
				dcnt_q <= '0;
			end else if (dcnt_inc) begin
				dcnt_q <= dcnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			status_q  <= st_d;
			element_q <= elem_d;
			last_q    <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign last      = last_q;

endmodule

>>> rtl/core/olad_chk.sv
// olad_chk: port-level checks for the ordered list block
// bound to ordered_list_append_delete_dump, watches only its ports
// depends on olad_pkg
module olad_chk
	import olad_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [1:0]               operation,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [2:0]               status,
	input logic signed [DATA_W-1:0] element,
	input logic                     last
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(element)
			&& $stable(last))
		else $error("stalled result beat changed");

	// only list element beats carry data
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_ELEMENT) |-> (element == '0))
		else $error("non-element beat with nonzero element");

	// single-result answers always close the item
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_ELEMENT) |-> last)
		else $error("single-result answer without last");

	// an append answers in the next cycle
	a_app: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == OP_APPEND) |=>
			out_valid && ((status == ST_APPENDED) || (status == ST_FULL)))
		else $error("append not answered next cycle");

endmodule

bind ordered_list_append_delete_dump olad_chk u_olad_chk (.*);

>>> bench/ordered_list_append_delete_dump_test.sv
// testbench for ordered_list_append_delete_dump: directed and random append, delete and dump
// traffic checked beat by beat against a queue-based model of the list
// depends on olad_pkg and the ordered_list_append_delete_dump rtl
`timescale 1ns / 100ps

module ordered_list_append_delete_dump_test;
	import olad_pkg::*;

	localparam int unsigned LIST_DEPTH = 16;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		status_t                  status;
		logic signed [DATA_W-1:0] element;
		logic                     last;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] operation;
	logic signed [DATA_W-1:0] value;
	logic out_valid;
	logic out_stall;
	logic [2:0] status;
	logic signed [DATA_W-1:0] element;
	logic last;

	logic signed [DATA_W-1:0] list_vals[$];
	list_result_t pending_results[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;

	ordered_list_append_delete_dump #(
		.DEPTH(LIST_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.element(element),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("ordered_list_append_delete_dump test failed");
		$finish;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 100)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic void push_result(input status_t st, input logic signed [DATA_W-1:0] el,
			input logic fin);
		list_result_t r;
		r.status = st;
		r.element = el;
		r.last = fin;
		pending_results.push_back(r);
	endfunction

	// list model: updates the held values and queues the beats the item should produce
	function automatic void apply_list_op(input logic [1:0] op,
			input logic signed [DATA_W-1:0] v);
		int hit;
		hit = -1;
		case (op)
			OP_APPEND: begin
				if (list_vals.size() >= LIST_DEPTH) begin
					push_result(ST_FULL, '0, 1'b1);
				end else begin
					list_vals.push_back(v);
					push_result(ST_APPENDED, '0, 1'b1);
				end
			end
			OP_DELETE: begin
				foreach (list_vals[i])
					if (hit < 0 && list_vals[i] == v)
						hit = i;
				if (hit < 0) begin
					push_result(ST_NOT_FOUND, '0, 1'b1);
				end else begin
					list_vals.delete(hit);
					push_result(ST_DELETED, '0, 1'b1);
				end
			end
			OP_DUMP: begin
				if (list_vals.size() == 0)
					push_result(ST_EMPTY, '0, 1'b1);
				else
					foreach (list_vals[i])
						push_result(ST_ELEMENT, list_vals[i], i == list_vals.size() - 1);
			end
			default: ;
		endcase
	endfunction

	task automatic send_beat(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
		int gap;
		gap = tx_gaps ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		value <= v;
		do @(posedge clk); while (in_stall);
		apply_list_op(op, v);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected beat status %0d element %0d last %0b",
					status, element, last));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (element !== want.element)
					report_mismatch($sformatf("element %0d, want %0d", element, want.element));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", last, want.last));
			end
		end
	end

	initial begin : result_stall
		int n;
		out_stall = 1'b0;
		forever begin
			n = rx_stalls ? pick_gap() : 0;
			@(negedge clk);
			out_stall <= (n != 0);
			if (n > 1)
				repeat (n - 1) @(negedge clk);
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $signed($urandom_range(0, 15)) - 8;
		if (r < 8)
			return $urandom();
		case ($urandom_range(0, 3))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			default: return -1;
		endcase
	endfunction

	task automatic test_empty_list();
		send_beat(OP_DUMP, '0);
		send_beat(OP_DELETE, 32'sd7);
	endtask

	// head and tail hold the extremes, a pair of duplicates sits just inside them
	task automatic test_fill_to_full();
		send_beat(OP_APPEND, VAL_MIN);
		send_beat(OP_APPEND, 32'sd5);
		send_beat(OP_APPEND, -1);
		for (int i = 0; i < LIST_DEPTH - 5; i++)
			send_beat(OP_APPEND, $urandom());
		send_beat(OP_APPEND, 32'sd5);
		send_beat(OP_APPEND, VAL_MAX);
		send_beat(OP_APPEND, '0);
		send_beat(OP_DUMP, '0);
	endtask

	task automatic test_delete_rules();
		send_beat(OP_DELETE, 32'sd5);
		send_beat(OP_DELETE, VAL_MIN);
		send_beat(OP_DELETE, VAL_MAX);
		send_beat(OP_DELETE, 32'sd123456);
		send_beat(OP_UNUSED, $urandom());
		send_beat(OP_DUMP, '0);
	endtask

	task automatic test_drain_pause();
		wait_results_drained();
		send_beat(OP_DUMP, '0);
		send_beat(OP_APPEND, 32'sd5);
	endtask

	// blocks alternate between growing and shrinking the list so full and empty both recur
	task automatic test_random_traffic();
		int r;
		logic [1:0] op;
		logic signed [DATA_W-1:0] v;
		for (int blk = 0; blk < 8; blk++) begin
			tx_gaps = (blk != 3 && blk != 6);
			rx_stalls = (blk != 3 && blk != 5);
			for (int k = 0; k < 50; k++) begin
				r = $urandom_range(0, 99);
				v = pick_value();
				if (r < ((blk % 2 == 0) ? 55 : 20)) begin
					op = OP_APPEND;
				end else if (r < 75) begin
					op = OP_DELETE;
					if (list_vals.size() != 0 && $urandom_range(0, 3) != 0)
						v = list_vals[$urandom_range(0, list_vals.size() - 1)];
				end else if (r < 95) begin
					op = OP_DUMP;
				end else begin
					op = OP_UNUSED;
				end
				send_beat(op, v);
			end
		end
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_APPEND;
		value = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_fill_to_full();
		test_delete_rules();
		test_drain_pause();
		test_random_traffic();

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d beats never arrived", pending_results.size()));
		if (error_count == 0)
			$display("ordered_list_append_delete_dump test passed");
		else
			$display("ordered_list_append_delete_dump test failed");
		$finish;
	end

endmodule
